>>> sv/rpu_pkg.sv
`default_nettype none
package rpu_pkg;

  localparam int PIX_W       = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    REG_IN_WIDTH = 1'b0,
    REG_SCALE    = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [10:0] in_width;
    logic [4:0]  scale;
  } cfg_t;

  // classified command, front to back
  typedef struct packed {
    logic       valid;
    logic       accepted;
    logic       pixel_valid;
    logic       row_end;
    logic [1:0] pad_bytes;
    logic       replay_done;
  } desc_t;

  typedef struct packed {
    logic       accepted;
    logic       pixel_valid;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       row_end;
    logic [1:0] pad_bytes;
    logic       replay_done;
  } item_t;

endpackage
`default_nettype wire

>>> sv/pixel_replicating_upscaler_top.sv
// channel   direction  handshake             payload
// in_       input      in_valid/in_ready     func, blue_in, green_in, red_in
// out_      output     out_valid/out_ready   accepted, pixel_valid, bgr, row_end, pad, done
// cfg_      APB        psel/penable/pready   0x0 in_width, 0x4 scale
//
// One item per cycle while in_ready is high; a result is staged in s1, then queued.
// Each pull costs one read of the single-port-read line buffer; pushes one write.
// A 4-entry result queue decouples the output: input stalls once queued plus staged
// results reach four.
// Reset (synchronous, active low) clears counters and queue; no clearing pass,
// the line buffer holds stale data until written.
`default_nettype none
module pixel_replicating_upscaler_top #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_SCALE = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_func,
  input  wire logic [7:0]  in_blue_in,
  input  wire logic [7:0]  in_green_in,
  input  wire logic [7:0]  in_red_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_accepted,
  output logic             out_pixel_valid,
  output logic [7:0]       out_blue_out,
  output logic [7:0]       out_green_out,
  output logic [7:0]       out_red_out,
  output logic             out_row_end,
  output logic [1:0]       out_pad_bytes,
  output logic             out_replay_done,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import rpu_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  cfg_t             cfg_r, cfg_nxt;
  desc_t            desc;
  logic             back_ready;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [PIX_W-1:0] ram_wdata, ram_rdata;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_IN_WIDTH: cfg_nxt.in_width = cfg_pwdata[10:0];
        REG_SCALE:    cfg_nxt.scale    = cfg_pwdata[4:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_IN_WIDTH: cfg_prdata = {21'd0, cfg_r.in_width};
      REG_SCALE:    cfg_prdata = {27'd0, cfg_r.scale};
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.in_width <= 11'd1;
      cfg_r.scale    <= 5'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rpu_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_func     (in_func),
    .in_blue_in  (in_blue_in),
    .in_green_in (in_green_in),
    .in_red_in   (in_red_in),
    .back_ready  (back_ready),
    .desc        (desc),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr)
  );

  rpu_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rpu_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .desc            (desc),
    .rdata           (ram_rdata),
    .back_ready      (back_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_accepted    (out_accepted),
    .out_pixel_valid (out_pixel_valid),
    .out_blue_out    (out_blue_out),
    .out_green_out   (out_green_out),
    .out_red_out     (out_red_out),
    .out_row_end     (out_row_end),
    .out_pad_bytes   (out_pad_bytes),
    .out_replay_done (out_replay_done)
  );

endmodule
`default_nettype wire

>>> sv/rpu_ram.sv
`default_nettype none
module rpu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/rpu_front.sv
`default_nettype none
module rpu_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_SCALE = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire rpu_pkg::cfg_t                  cfg,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_func,
  input  wire logic [7:0]                     in_blue_in,
  input  wire logic [7:0]                     in_green_in,
  input  wire logic [7:0]                     in_red_in,
  input  wire logic                           back_ready,
  output rpu_pkg::desc_t                      desc,
  output logic                                ram_we,
  output logic [$clog2(MAX_WIDTH)-1:0]        ram_waddr,
  output logic [rpu_pkg::PIX_W-1:0]           ram_wdata,
  output logic [$clog2(MAX_WIDTH)-1:0]        ram_raddr
);
  import rpu_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_SCALE);
  localparam int SW = $clog2(MAX_SCALE + 1);

  logic [WW-1:0] fill_r, fill_nxt;
  logic          ready_r, ready_nxt;
  logic [AW-1:0] col_r, col_nxt;
  logic [HW-1:0] h_r, h_nxt;
  logic [HW-1:0] v_r, v_nxt;

  logic [WW-1:0] w;
  logic [SW-1:0] s;
  logic [WW-1:0] fill_inc;
  logic          hit, push, pull;
  logic          last_h, last_col, last_v;

  always_comb begin
    if (cfg.in_width == '0) begin
      w = WW'(1);
    end else if (32'(cfg.in_width) > 32'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(cfg.in_width);
    end
    if (cfg.scale == '0) begin
      s = SW'(1);
    end else if (32'(cfg.scale) > 32'(MAX_SCALE)) begin
      s = SW'(MAX_SCALE);
    end else begin
      s = SW'(cfg.scale);
    end
  end

  assign in_ready = back_ready;
  assign hit      = in_valid && in_ready;
  assign push     = hit && !in_func && !ready_r;
  assign pull     = hit && in_func && ready_r;
  assign fill_inc = fill_r + WW'(1);

  assign last_h   = ((SW+1)'(h_r) + (SW+1)'(1)) >= (SW+1)'(s);
  assign last_v   = ((SW+1)'(v_r) + (SW+1)'(1)) >= (SW+1)'(s);
  assign last_col = ((WW+1)'(col_r) + (WW+1)'(1)) >= (WW+1)'(w);

  assign ram_we    = push && (32'(fill_r) < 32'(MAX_WIDTH));
  assign ram_waddr = AW'(fill_r);
  assign ram_wdata = {in_red_in, in_green_in, in_blue_in};
  assign ram_raddr = col_r;

  always_comb begin
    desc             = '0;
    desc.valid       = hit;
    desc.accepted    = push;
    desc.pixel_valid = pull;
    desc.row_end     = pull && last_h && last_col;
    desc.pad_bytes   = (pull && last_h && last_col) ? 2'(w[1:0] * s[1:0]) : 2'd0;
    desc.replay_done = pull && last_h && last_col && last_v;
  end

  always_comb begin
    fill_nxt  = fill_r;
    ready_nxt = ready_r;
    col_nxt   = col_r;
    h_nxt     = h_r;
    v_nxt     = v_r;
    if (push) begin
      fill_nxt = fill_inc;
      if (fill_inc >= w) begin
        ready_nxt = 1'b1;
        col_nxt   = '0;
        h_nxt     = '0;
        v_nxt     = '0;
      end
    end else if (pull) begin
      if (!last_h) begin
        h_nxt = h_r + HW'(1);
      end else begin
        h_nxt = '0;
        if (!last_col) begin
          col_nxt = col_r + AW'(1);
        end else begin
          col_nxt = '0;
          if (!last_v) begin
            v_nxt = v_r + HW'(1);
          end else begin
            v_nxt     = '0;
            ready_nxt = 1'b0;
            fill_nxt  = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      ready_r <= 1'b0;
      col_r   <= '0;
      h_r     <= '0;
      v_r     <= '0;
    end else begin
      fill_r  <= fill_nxt;
      ready_r <= ready_nxt;
      col_r   <= col_nxt;
      h_r     <= h_nxt;
      v_r     <= v_nxt;
    end
  end

  a_no_write_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !ready_r)
    else $error("row store written while row ready");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= 32'(MAX_WIDTH))
    else $error("fill count past store depth");

  a_replay_frees: assert property (@(posedge clk) disable iff (!rst_n)
    desc.replay_done |=> !ready_r && fill_r == '0)
    else $error("row store not freed after final replica");

endmodule
`default_nettype wire

>>> sv/rpu_back.sv
`default_nettype none
module rpu_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire rpu_pkg::desc_t             desc,
  input  wire logic [rpu_pkg::PIX_W-1:0]  rdata,
  output logic                            back_ready,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_accepted,
  output logic                            out_pixel_valid,
  output logic [7:0]                      out_blue_out,
  output logic [7:0]                      out_green_out,
  output logic [7:0]                      out_red_out,
  output logic                            out_row_end,
  output logic [1:0]                      out_pad_bytes,
  output logic                            out_replay_done
);
  import rpu_pkg::*;

  logic                s1_valid_r;
  desc_t               s1_r;
  item_t               q_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr_r, rptr_r;
  logic [QUEUE_CW-1:0] count_r, count_nxt;
  item_t               entry, head;
  logic                enq, deq;

  always_comb begin
    entry             = '0;
    entry.accepted    = s1_r.accepted;
    entry.pixel_valid = s1_r.pixel_valid;
    if (s1_r.pixel_valid) begin
      entry.red   = rdata[23:16];
      entry.green = rdata[15:8];
      entry.blue  = rdata[7:0];
    end
    entry.row_end     = s1_r.row_end;
    entry.pad_bytes   = s1_r.pad_bytes;
    entry.replay_done = s1_r.replay_done;
  end

  assign enq        = s1_valid_r;
  assign out_valid  = count_r != '0;
  assign deq        = out_valid && out_ready;
  assign back_ready = ((QUEUE_CW+1)'(count_r) + (QUEUE_CW+1)'(s1_valid_r))
                      < (QUEUE_CW+1)'(QUEUE_DEPTH);
  assign count_nxt  = count_r + QUEUE_CW'(enq) - QUEUE_CW'(deq);

  assign head            = q_r[rptr_r];
  assign out_accepted    = head.accepted;
  assign out_pixel_valid = head.pixel_valid;
  assign out_blue_out    = head.blue;
  assign out_green_out   = head.green;
  assign out_red_out     = head.red;
  assign out_row_end     = head.row_end;
  assign out_pad_bytes   = head.pad_bytes;
  assign out_replay_done = head.replay_done;

  always_ff @(posedge clk) begin
    s1_r <= desc;
    if (enq) begin
      q_r[wptr_r] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      wptr_r     <= '0;
      rptr_r     <= '0;
      count_r    <= '0;
    end else begin
      s1_valid_r <= desc.valid;
      if (enq) begin
        wptr_r <= wptr_r + QUEUE_AW'(1);
      end
      if (deq) begin
        rptr_r <= rptr_r + QUEUE_AW'(1);
      end
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(QUEUE_DEPTH))
    else $error("queue overfilled");

  a_room_for_stage: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> 32'(count_r) < 32'(QUEUE_DEPTH) || deq)
    else $error("no room for staged transfer");

  a_kind_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    enq |-> !(s1_r.accepted && s1_r.pixel_valid))
    else $error("push and pull flags both set");

endmodule
`default_nettype wire

>>> bench/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rpu_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_S = 16;
  localparam int HOLD_CYCLES = 200;
  localparam int WATCHDOG = 2000;
  localparam int RANDOM_ITEMS = 100;
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_PULL = 1'b1;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready, in_func;
  logic [7:0] in_blue_in, in_green_in, in_red_in;
  logic out_valid, out_ready, out_accepted, out_pixel_valid;
  logic [7:0] out_blue_out, out_green_out, out_red_out;
  logic out_row_end, out_replay_done;
  logic [1:0] out_pad_bytes;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  pixel_replicating_upscaler_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_blue_in(in_blue_in), .in_green_in(in_green_in), .in_red_in(in_red_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_accepted(out_accepted), .out_pixel_valid(out_pixel_valid),
    .out_blue_out(out_blue_out), .out_green_out(out_green_out),
    .out_red_out(out_red_out), .out_row_end(out_row_end),
    .out_pad_bytes(out_pad_bytes), .out_replay_done(out_replay_done),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #10ns clk = ~clk;

  // shadow of the upscaler
  logic [23:0] row_buf [MAX_W];
  logic [10:0] cur_width = 11'd1;
  logic [4:0]  cur_scale = 5'd1;
  int  fill_cnt = 0;
  bit  row_full = 1'b0;
  int  col = 0;
  int  hrep = 0;
  int  vrep = 0;

  item_t expected_px[$];
  int  errors = 0;
  int  useful_cmds = 0;
  bit  idle_on = 1'b1;
  bit  hold_req = 1'b0;
  int  stall_cnt = 0;

  function automatic int eff_width(logic [10:0] v);
    if (v == 0) return 1;
    if (v > MAX_W) return MAX_W;
    return int'(v);
  endfunction

  function automatic int eff_scale(logic [4:0] v);
    if (v == 0) return 1;
    if (v > MAX_S) return MAX_S;
    return int'(v);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [23:0] rand_px();
    return 24'($urandom());
  endfunction

  task automatic upscale_predict(input logic func, input logic [23:0] px);
    item_t res;
    int w, s;
    logic [23:0] word;
    bit end_h, end_col, end_v;
    res = '0;
    w = eff_width(cur_width);
    s = eff_scale(cur_scale);
    if (func == FUNC_PUSH) begin
      if (!row_full) begin
        if (fill_cnt < MAX_W) row_buf[fill_cnt] = px;
        fill_cnt++;
        res.accepted = 1'b1;
        if (fill_cnt >= w) begin
          row_full = 1'b1;
          col = 0;
          hrep = 0;
          vrep = 0;
        end
      end
    end else if (row_full) begin
      word = row_buf[col];
      end_h = (hrep + 1 >= s);
      end_col = (col + 1 >= w);
      end_v = (vrep + 1 >= s);
      res.pixel_valid = 1'b1;
      res.blue = word[7:0];
      res.green = word[15:8];
      res.red = word[23:16];
      if (end_h && end_col) begin
        res.row_end = 1'b1;
        res.pad_bytes = 2'((w * s) % 4);
      end
      if (!end_h) begin
        hrep++;
      end else begin
        hrep = 0;
        if (!end_col) begin
          col++;
        end else begin
          col = 0;
          if (!end_v) begin
            vrep++;
          end else begin
            vrep = 0;
            row_full = 1'b0;
            fill_cnt = 0;
            res.replay_done = 1'b1;
          end
        end
      end
    end
    if (res.accepted || res.pixel_valid) useful_cmds++;
    expected_px.push_back(res);
  endtask

  // px is {red, green, blue}
  task automatic send_cmd(input logic func, input logic [23:0] px);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_func <= func;
    in_blue_in <= px[7:0];
    in_green_in <= px[15:8];
    in_red_in <= px[23:16];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    upscale_predict(func, px);
  endtask

  task automatic fill_row(input int noise_pct);
    while (!row_full) begin
      if ($urandom_range(0, 99) < noise_pct) send_cmd(FUNC_PULL, rand_px());
      else send_cmd(FUNC_PUSH, rand_px());
    end
  endtask

  task automatic replay_row(input int noise_pct, input int max_pulls);
    int pulls;
    pulls = 0;
    while (row_full && pulls < max_pulls) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_cmd(FUNC_PUSH, rand_px());
      end else begin
        send_cmd(FUNC_PULL, rand_px());
        pulls++;
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    // a wider row while one is held would read unwritten store entries
    if (idx == REG_IN_WIDTH && row_full && eff_width(val[10:0]) > eff_width(cur_width))
      replay_row(0, 1 << 30);
    wait_drained();
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_IN_WIDTH) cur_width = val[10:0];
    else cur_scale = val[4:0];
  endtask

  function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_px.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        want = expected_px.pop_front();
        check_field("accepted", want.accepted, out_accepted);
        check_field("pixel_valid", want.pixel_valid, out_pixel_valid);
        check_field("blue_out", want.blue, out_blue_out);
        check_field("green_out", want.green, out_green_out);
        check_field("red_out", want.red, out_red_out);
        check_field("row_end", want.row_end, out_row_end);
        check_field("pad_bytes", want.pad_bytes, out_pad_bytes);
        check_field("replay_done", want.replay_done, out_replay_done);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_psel && cfg_penable))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= WATCHDOG) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : result_sink
    int gap_left;
    gap_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (gap_left > 0) begin
        out_ready <= 1'b0;
        gap_left--;
      end else begin
        out_ready <= 1'b1;
        if (idle_on) gap_left = pick_gap();
      end
    end
  end

  // reset config: one pixel, no scaling
  task automatic test_idle_row();
    send_cmd(FUNC_PULL, 24'hFFFFFF);
    send_cmd(FUNC_PUSH, 24'h123456);
    send_cmd(FUNC_PUSH, 24'hABCDEF);
    send_cmd(FUNC_PULL, 24'h000000);
    send_cmd(FUNC_PULL, 24'h000000);
  endtask

  task automatic test_color_extremes();
    write_reg(REG_IN_WIDTH, 32'd3);
    send_cmd(FUNC_PUSH, 24'h000000);
    send_cmd(FUNC_PUSH, 24'hFFFFFF);
    send_cmd(FUNC_PUSH, 24'hC35AA5);
    repeat (3) send_cmd(FUNC_PULL, 24'hFFFFFF);
  endtask

  // registers changed while a row is being replayed
  task automatic test_midrow_retune();
    write_reg(REG_IN_WIDTH, 32'd4);
    write_reg(REG_SCALE, 32'd3);
    fill_row(0);
    replay_row(0, 5);
    write_reg(REG_SCALE, 32'd2);
    replay_row(0, 3);
    write_reg(REG_IN_WIDTH, 32'd2);
    replay_row(0, 1 << 30);
  endtask

  task automatic test_output_stall();
    write_reg(REG_IN_WIDTH, 32'd8);
    write_reg(REG_SCALE, 32'd2);
    idle_on = 1'b0;
    hold_req = 1'b1;
    fill_row(0);
    replay_row(0, 1 << 30);
    wait_drained();
    idle_on = 1'b1;
  endtask

  // width above the store depth: row completes at the store depth
  task automatic test_width_clamp();
    write_reg(REG_SCALE, 32'd1);
    write_reg(REG_IN_WIDTH, 32'd2047);
    fill_row(0);
    send_cmd(FUNC_PUSH, rand_px());
    write_reg(REG_IN_WIDTH, 32'd2);
    replay_row(0, 1 << 30);
  endtask

  task automatic test_random_frames();
    int corner_w [3] = '{0, 1, 7};
    int corner_s [3] = '{0, 31, 5};
    int target, kind, w, s, n;
    for (int i = 0; i < 3; i++) begin
      write_reg(REG_IN_WIDTH, corner_w[i]);
      write_reg(REG_SCALE, corner_s[i]);
      fill_row(10);
      replay_row(10, 1 << 30);
    end
    target = useful_cmds + RANDOM_ITEMS;
    while (useful_cmds < target) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1) == 0) begin
        n = $urandom_range(0, 99);
        if (n < 70) w = $urandom_range(1, 12);
        else if (n < 95) w = $urandom_range(13, 64);
        else if (n < 97) w = 0;
        else w = $urandom_range(65, 96);
        n = $urandom_range(0, 99);
        if (w > 16) s = $urandom_range(1, 2);
        else if (n < 60) s = $urandom_range(1, 3);
        else if (n < 85) s = $urandom_range(4, 6);
        else if (n < 95) s = 0;
        else s = (w <= 1) ? $urandom_range(17, 31) : 2;
        write_reg(REG_IN_WIDTH, w);
        write_reg(REG_SCALE, s);
      end
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat (20) send_cmd(1'($urandom()), rand_px());
      end else if (kind == 1) begin
        // abandoned fill
        n = $urandom_range(0, eff_width(cur_width));
        for (int k = 0; k < n && !row_full; k++) send_cmd(FUNC_PUSH, rand_px());
      end else if (kind == 2) begin
        fill_row(10);
        replay_row(10, $urandom_range(1, 40));
      end else begin
        fill_row(10);
        replay_row(10, 1 << 30);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_PUSH;
    in_blue_in = '0;
    in_green_in = '0;
    in_red_in = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_idle_row();
    test_color_extremes();
    test_midrow_retune();
    test_output_stall();
    test_width_clamp();
    test_random_frames();
    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
